// File: design/sctc_pkg.sv
package sctc_pkg;

   localparam int TABLE_ROWS          = 128;
   localparam int TABLE_COLUMNS       = 6;
   localparam int TABLE_ENTRIES       = TABLE_ROWS * TABLE_COLUMNS;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int ROW_W   = 7;
   localparam int COL_W   = 3;
   localparam int INDEX_W = 10;
   localparam int WORD_W  = 16;
   localparam int CHAR_W  = 8;
   localparam int LOCK_W  = 3;
   localparam int MOD_W   = 6;

   // index / 6 as (index * 683) >> 12, exact for index < 768
   localparam int DIV6_MUL   = 683;
   localparam int DIV6_SHIFT = 12;
   localparam int PROD_W     = 20;

   localparam int RELEASE_BIT = 7;
   localparam int CAPS_BIT    = 15;

   localparam logic [ROW_W-1:0] PAD_SLASH_CODE   = 7'h35;
   localparam logic [ROW_W-1:0] RIGHT_SHIFT_CODE = 7'h36;
   localparam logic [ROW_W-1:0] PAD_CODE_FIRST   = 7'h47;
   localparam logic [ROW_W-1:0] PAD_CODE_LAST    = 7'h53;

   localparam logic [WORD_W-1:0] VAL_PREFIX     = 16'h1000;
   localparam logic [WORD_W-1:0] VAL_CTRL       = 16'h0200;
   localparam logic [WORD_W-1:0] VAL_SHIFT      = 16'h0400;
   localparam logic [WORD_W-1:0] VAL_ALT        = 16'h0800;
   localparam logic [WORD_W-1:0] VAL_CAPS_KEY   = 16'h010D;
   localparam logic [WORD_W-1:0] VAL_NUM_KEY    = 16'h010E;
   localparam logic [WORD_W-1:0] VAL_SCROLL_KEY = 16'h010F;
   localparam logic [WORD_W-1:0] VAL_PAD_FIRST  = 16'h0101;
   localparam logic [WORD_W-1:0] VAL_PAD_LAST   = 16'h010C;

   localparam logic [CHAR_W-1:0] ESC_BYTE     = 8'h1B;
   localparam logic [CHAR_W-1:0] BRACKET_BYTE = 8'h5B;
   localparam logic [CHAR_W-1:0] SLASH_BYTE   = 8'h2F;

   // lock bits
   localparam int LK_SCROLL = 0;
   localparam int LK_NUM    = 1;
   localparam int LK_CAPS   = 2;

   // modifier bits
   localparam int MK_CTRL_L  = 0;
   localparam int MK_CTRL_R  = 1;
   localparam int MK_SHIFT_L = 2;
   localparam int MK_SHIFT_R = 3;
   localparam int MK_ALT_L   = 4;
   localparam int MK_ALT_R   = 5;

   // keymap columns
   localparam logic [COL_W-1:0] COL_PLAIN     = 3'd0;
   localparam logic [COL_W-1:0] COL_SHIFT     = 3'd1;
   localparam logic [COL_W-1:0] COL_ALT       = 3'd2;
   localparam logic [COL_W-1:0] COL_ALTGR     = 3'd3;
   localparam logic [COL_W-1:0] COL_ALT_SHIFT = 3'd4;
   localparam logic [COL_W-1:0] COL_CTRL      = 3'd5;

   typedef enum logic {
      OP_SCAN,
      OP_WRITE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic                press;
      logic [WORD_W-1:0]   word;
   } entry_type;

   function automatic logic [CHAR_W-1:0] pad_letter(input logic [3:0] idx);
      logic [CHAR_W-1:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h48; // H
         4'd1:    ch = 8'h59; // Y
         4'd2:    ch = 8'h41; // A
         4'd3:    ch = 8'h42; // B
         4'd4:    ch = 8'h44; // D
         4'd5:    ch = 8'h43; // C
         4'd6:    ch = 8'h56; // V
         4'd7:    ch = 8'h55; // U
         4'd8:    ch = 8'h47; // G
         4'd9:    ch = 8'h53; // S
         4'd10:   ch = 8'h54; // T
         default: ch = 8'h40; // @
      endcase
      return ch;
   endfunction

endpackage

// File: design/sctc_ram.sv
module sctc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/sctc_front.sv
module sctc_front (
   input  logic                           push,
   input  logic                           full,
   input  logic                           req_type,
   input  logic [7:0]                     req_scan_byte,
   input  logic [sctc_pkg::INDEX_W-1:0]   req_map_index,
   input  logic [sctc_pkg::WORD_W-1:0]    req_map_word,
   output logic                           q_push,
   output sctc_pkg::entry_type            q_entry
);
   import sctc_pkg::*;

   logic                 accept;
   logic                 in_range;
   logic [PROD_W-1:0]    prod;
   logic [ROW_W-1:0]     wr_row;
   logic [INDEX_W-1:0]   row_x6;
   logic [INDEX_W-1:0]   col_rem;

   assign accept   = push && !full;
   assign in_range = req_map_index < INDEX_W'(TABLE_ENTRIES);

   // row = index / 6 by reciprocal, column = remainder
   assign prod    = PROD_W'(req_map_index) * PROD_W'(DIV6_MUL);
   assign wr_row  = prod[DIV6_SHIFT +: ROW_W];
   assign row_x6  = {1'b0, wr_row, 2'b00} + {2'b00, wr_row, 1'b0};
   assign col_rem = req_map_index - row_x6;

   always_comb begin
      q_entry = '0;
      if (req_type) begin
         q_entry.op   = OP_WRITE;
         q_entry.row  = wr_row;
         q_entry.col  = col_rem[COL_W-1:0];
         q_entry.word = req_map_word;
      end else begin
         q_entry.op    = OP_SCAN;
         q_entry.row   = req_scan_byte[ROW_W-1:0];
         q_entry.press = !req_scan_byte[RELEASE_BIT];
      end
   end

   // out-of-range keymap writes are taken and dropped here
   assign q_push = accept && (!req_type || in_range);

endmodule

// File: design/sctc_queue.sv
module sctc_queue #(
   parameter int DEPTH = sctc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sctc_pkg::entry_type  wr_entry,
   output logic                 full,
   input  logic                 pop,
   output sctc_pkg::entry_type  rd_entry,
   output logic                 valid
);
   import sctc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign valid    = count_ff != '0;
   assign rd_entry = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

// File: design/sctc_back.sv
module sctc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  sctc_pkg::entry_type           q_entry,
   output logic                          q_pop,
   input  logic                          pop,
   output logic                          empty,
   output logic [sctc_pkg::CHAR_W-1:0]   rsp_char_code,
   output logic                          rsp_last_of_run,
   output logic [sctc_pkg::LOCK_W-1:0]   rsp_lock_state
);
   import sctc_pkg::*;

   localparam logic [1:0] EMIT_NONE  = 2'd0;
   localparam logic [1:0] EMIT_LAST  = 2'd1;
   localparam logic [1:0] EMIT_BRKT  = 2'd2;
   localparam logic [1:0] EMIT_ESC   = 2'd3;

   // read stage
   logic                take, rd_en, wr_en;
   logic [WORD_W-1:0]   rd_data [TABLE_COLUMNS];

   // decode stage
   logic                b_valid_ff, b_valid_in;
   logic [ROW_W-1:0]    b_code_ff;
   logic                b_press_ff;
   logic                b_adv;

   // key state
   logic                prefix_ff, prefix_in;
   logic [MOD_W-1:0]    mods_ff, mods_in;
   logic [LOCK_W-1:0]   held_ff, held_in;
   logic [LOCK_W-1:0]   lock_ff, lock_in;

   // result register
   logic [1:0]          emit_cnt_ff, emit_cnt_in;
   logic [CHAR_W-1:0]   emit_char_ff, emit_char_in;
   logic [LOCK_W-1:0]   emit_lock_ff;
   logic                emit_free, emit_load;

   logic                shifted, ctl, alt, in_pad, inv;
   logic [COL_W-1:0]    col_sel;
   logic [WORD_W-1:0]   entry;
   logic [WORD_W-1:0]   val;
   logic [WORD_W-1:0]   pad_off;

   // ---- read stage: one queue entry per cycle; a scan entry waits while decode is stalled
   assign emit_free = (emit_cnt_ff == EMIT_NONE) || ((emit_cnt_ff == EMIT_LAST) && pop);
   assign b_adv     = b_valid_ff && emit_free;
   assign take      = q_valid && ((q_entry.op == OP_WRITE) || !b_valid_ff || b_adv);
   assign q_pop     = take;
   assign rd_en     = take && (q_entry.op == OP_SCAN);
   assign wr_en     = take && (q_entry.op == OP_WRITE);

   for (genvar i = 0; i < TABLE_COLUMNS; i++) begin : g_col
      sctc_ram #(
         .WIDTH (WORD_W),
         .DEPTH (TABLE_ROWS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en && (q_entry.col == COL_W'(i))),
         .wr_addr (q_entry.row),
         .wr_data (q_entry.word),
         .rd_en   (rd_en),
         .rd_addr (q_entry.row),
         .rd_data (rd_data[i])
      );
   end

   // ---- decode stage: column choice and keymap value
   always_comb begin
      shifted = mods_ff[MK_SHIFT_L] | mods_ff[MK_SHIFT_R];
      ctl     = mods_ff[MK_CTRL_L] | mods_ff[MK_CTRL_R];
      alt     = mods_ff[MK_ALT_L] | mods_ff[MK_ALT_R];
      in_pad  = (b_code_ff >= PAD_CODE_FIRST) && (b_code_ff <= PAD_CODE_LAST);
      inv     = shifted ^ (lock_ff[LK_NUM] & in_pad)
              ^ (lock_ff[LK_CAPS] & rd_data[0][CAPS_BIT]);
      if (alt) begin
         if (inv) begin
            col_sel = COL_ALT_SHIFT;
         end else if (ctl || mods_ff[MK_ALT_R]) begin
            col_sel = COL_ALTGR;
         end else begin
            col_sel = COL_ALT;
         end
      end else if (ctl) begin
         col_sel = COL_CTRL;
      end else if (inv) begin
         col_sel = COL_SHIFT;
      end else begin
         col_sel = COL_PLAIN;
      end
      unique case (col_sel)
         COL_PLAIN:     entry = rd_data[0];
         COL_SHIFT:     entry = rd_data[1];
         COL_ALT:       entry = rd_data[2];
         COL_ALTGR:     entry = rd_data[3];
         COL_ALT_SHIFT: entry = rd_data[4];
         COL_CTRL:      entry = rd_data[5];
         default:       entry = rd_data[0];
      endcase
      if ((b_code_ff == PAD_SLASH_CODE) && prefix_ff) begin
         val = {{(WORD_W-CHAR_W){1'b0}}, SLASH_BYTE};
      end else begin
         val = {1'b0, entry[WORD_W-2:0]};
      end
      pad_off = val - VAL_PAD_FIRST;
   end

   // ---- state update and result load
   always_comb begin
      prefix_in    = prefix_ff;
      mods_in      = mods_ff;
      held_in      = held_ff;
      lock_in      = lock_ff;
      emit_load    = 1'b0;
      emit_cnt_in  = emit_cnt_ff;
      emit_char_in = emit_char_ff;
      if (b_adv) begin
         prefix_in = 1'b0;
         unique case (val)
            VAL_CTRL: begin
               if (prefix_ff) mods_in[MK_CTRL_R] = b_press_ff;
               else           mods_in[MK_CTRL_L] = b_press_ff;
            end
            VAL_SHIFT: begin
               if (b_code_ff == RIGHT_SHIFT_CODE) mods_in[MK_SHIFT_R] = b_press_ff;
               else                               mods_in[MK_SHIFT_L] = b_press_ff;
            end
            VAL_ALT: begin
               if (prefix_ff) mods_in[MK_ALT_R] = b_press_ff;
               else           mods_in[MK_ALT_L] = b_press_ff;
            end
            VAL_CAPS_KEY: begin
               if (b_press_ff && !held_ff[LK_CAPS]) lock_in[LK_CAPS] = !lock_ff[LK_CAPS];
               held_in[LK_CAPS] = b_press_ff;
            end
            VAL_NUM_KEY: begin
               if (b_press_ff && !held_ff[LK_NUM]) lock_in[LK_NUM] = !lock_ff[LK_NUM];
               held_in[LK_NUM] = b_press_ff;
            end
            VAL_SCROLL_KEY: begin
               if (b_press_ff && !held_ff[LK_SCROLL]) lock_in[LK_SCROLL] = !lock_ff[LK_SCROLL];
               held_in[LK_SCROLL] = b_press_ff;
            end
            VAL_PREFIX: begin
               prefix_in = 1'b1;
            end
            default: begin
               if (b_press_ff && (val != '0) && (val[WORD_W-1:CHAR_W] == '0)) begin
                  emit_load    = 1'b1;
                  emit_cnt_in  = EMIT_LAST;
                  emit_char_in = val[CHAR_W-1:0];
               end else if (b_press_ff && (val >= VAL_PAD_FIRST) && (val <= VAL_PAD_LAST)) begin
                  emit_load    = 1'b1;
                  emit_cnt_in  = EMIT_ESC;
                  emit_char_in = pad_letter(pad_off[3:0]);
               end
            end
         endcase
      end
      if (!emit_load && pop && (emit_cnt_ff != EMIT_NONE)) begin
         emit_cnt_in = emit_cnt_ff - 1'b1;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (rd_en) begin
         b_valid_in = 1'b1;
      end else if (b_adv) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         prefix_ff   <= 1'b0;
         mods_ff     <= '0;
         held_ff     <= '0;
         lock_ff     <= '0;
         emit_cnt_ff <= EMIT_NONE;
      end else begin
         b_valid_ff  <= b_valid_in;
         prefix_ff   <= prefix_in;
         mods_ff     <= mods_in;
         held_ff     <= held_in;
         lock_ff     <= lock_in;
         emit_cnt_ff <= emit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         b_code_ff  <= q_entry.row;
         b_press_ff <= q_entry.press;
      end
      emit_char_ff <= emit_char_in;
      if (emit_load) begin
         emit_lock_ff <= lock_ff;
      end
   end

   // ---- result port
   assign empty           = emit_cnt_ff == EMIT_NONE;
   assign rsp_last_of_run = emit_cnt_ff == EMIT_LAST;
   assign rsp_lock_state  = emit_lock_ff;

   always_comb begin
      unique case (emit_cnt_ff)
         EMIT_ESC:  rsp_char_code = ESC_BYTE;
         EMIT_BRKT: rsp_char_code = BRACKET_BYTE;
         default:   rsp_char_code = emit_char_ff;
      endcase
   end

endmodule

// File: design/scan_code_to_char_translator_top.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------------------------
// request   | in        | push / full          | req_type, req_scan_byte, req_map_index,
//           |           |                      | req_map_word
// response  | out       | empty / pop          | rsp_char_code, rsp_last_of_run,
//           |           |                      | rsp_lock_state
//
// A transaction is taken every cycle while the entry queue has room. A scan code waits in
// the queue, has its keymap row read into the RAM read registers and is decoded into the
// result register; decode takes a new code every cycle while the result side is free. Plain
// keys give one result, numeric-pad keys three, one per cycle while pop is high.
// Reset is synchronous and clears modifiers, locks, prefix and the queue, not the keymap.
// A stalled result side backs up into the queue; full rises once QUEUE_DEPTH wait in it.
module scan_code_to_char_translator_top #(
   parameter int QUEUE_DEPTH = sctc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          push,
   output logic                          full,
   input  logic                          req_type,
   input  logic [7:0]                    req_scan_byte,
   input  logic [sctc_pkg::INDEX_W-1:0]  req_map_index,
   input  logic [sctc_pkg::WORD_W-1:0]   req_map_word,
   // response side
   output logic                          empty,
   input  logic                          pop,
   output logic [sctc_pkg::CHAR_W-1:0]   rsp_char_code,
   output logic                          rsp_last_of_run,
   output logic [sctc_pkg::LOCK_W-1:0]   rsp_lock_state
);
   import sctc_pkg::*;

   // front to queue
   logic        q_push;
   entry_type   q_wr_entry;
   // queue to back
   logic        q_valid;
   logic        q_pop;
   entry_type   q_rd_entry;

   // front: classify, split keymap index into row and column, drop bad writes
   sctc_front u_front (
      .push          (push),
      .full          (full),
      .req_type      (req_type),
      .req_scan_byte (req_scan_byte),
      .req_map_index (req_map_index),
      .req_map_word  (req_map_word),
      .q_push        (q_push),
      .q_entry       (q_wr_entry)
   );

   // decoupling queue; full only reflects its occupancy
   sctc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (q_wr_entry),
      .full     (full),
      .pop      (q_pop),
      .rd_entry (q_rd_entry),
      .valid    (q_valid)
   );

   // back: keymap RAMs, modifier and lock tracking, result sequencing
   sctc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_entry         (q_rd_entry),
      .q_pop           (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_char_code   (rsp_char_code),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_lock_state  (rsp_lock_state)
   );

   // ---- assertions

   // nothing to deliver right after reset
   a_empty_after_reset : assert property (@(posedge clock)
      ($past(reset) && !reset) |-> empty)
      else $error("result present right after reset");

   // back never pulls from an empty queue
   a_pop_needs_entry : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // an ESC that opens a pad sequence is followed by the bracket byte
   a_pad_sequence : assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_of_run && (rsp_char_code == ESC_BYTE))
      |=> (!empty && !rsp_last_of_run && (rsp_char_code == BRACKET_BYTE)))
      else $error("pad sequence broken after ESC");

   // a byte taken while it is not last of its run leaves more still pending
   a_run_ends : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_last_of_run && pop) |=> !empty)
      else $error("run ended without final byte");

endmodule
